// File: rtl/lcas_pkg.sv
package lcas_pkg;

  localparam int MaxWidth  = 1024;
  localparam int MaxHeight = 1024;

  localparam int SizeW   = 11;
  localparam int ColW    = $clog2(MaxWidth);
  localparam int RowW    = $clog2(MaxHeight);
  localparam int CfgIdxW = 2;

  localparam logic [SizeW-1:0] MinSize     = SizeW'(3);
  localparam logic [SizeW-1:0] MaxWidthV   = SizeW'(MaxWidth);
  localparam logic [SizeW-1:0] MaxHeightV  = SizeW'(MaxHeight);
  localparam logic [SizeW-1:0] ResetWidth  = SizeW'(640);
  localparam logic [SizeW-1:0] ResetHeight = SizeW'(480);

  typedef enum logic [CfgIdxW-1:0] {
    IDX_GRID_WIDTH  = 2'd0,
    IDX_GRID_HEIGHT = 2'd1
  } cfg_idx_e;

  // One column of the neighborhood: bit 0 row above, bit 1 own row, bit 2 row below.
  typedef logic [2:0] col_t;

  typedef struct packed {
    logic            v;
    logic [ColW-1:0] ix;
    logic            emit;
    logic            ix0;
    logic            lmask;
    col_t            rowmask;
    logic [ColW-1:0] ox;
    logic [RowW-1:0] oy;
    logic            last;
  } stage_t;

  typedef struct packed {
    logic            new_alive;
    logic [ColW-1:0] cell_x;
    logic [RowW-1:0] cell_y;
    logic            last_cell;
  } res_t;

  function automatic logic [SizeW-1:0] clamp_size(logic [SizeW-1:0] v,
                                                  logic [SizeW-1:0] hi);
    logic [SizeW-1:0] r;
    if (v < MinSize) begin
      r = MinSize;
    end else if (v > hi) begin
      r = hi;
    end else begin
      r = v;
    end
    return r;
  endfunction

  function automatic logic [1:0] bits3(col_t c);
    return {1'b0, c[0]} + {1'b0, c[1]} + {1'b0, c[2]};
  endfunction

  function automatic logic life_next(col_t l, col_t m, col_t r, col_t rowmask);
    logic [3:0] n;
    logic       res;
    n = {2'b00, bits3(l & rowmask)} + {2'b00, bits3(r & rowmask)}
      + {2'b00, bits3(m & rowmask & 3'b101)};
    if (n == 4'd3) begin
      res = 1'b1;
    end else if (n == 4'd2) begin
      res = m[1];
    end else begin
      res = 1'b0;
    end
    return res;
  endfunction

endpackage

// File: rtl/lcas_if.sv
interface lcas_in_if;
  logic valid;
  logic ready;
  logic req_type;
  logic cell_alive;

  modport source (output valid, output req_type, output cell_alive, input ready);
  modport sink   (input valid, input req_type, input cell_alive, output ready);
endinterface

interface lcas_out_if;
  logic                     valid;
  logic                     ready;
  logic                     new_alive;
  logic [lcas_pkg::ColW-1:0] cell_x;
  logic [lcas_pkg::RowW-1:0] cell_y;
  logic                     last_cell;

  modport source (output valid, output new_alive, output cell_x, output cell_y,
                  output last_cell, input ready);
  modport sink   (input valid, input new_alive, input cell_x, input cell_y,
                  input last_cell, output ready);
endinterface

// File: rtl/lcas_ram.sv
module lcas_ram #(
  parameter int Width = 2,
  parameter int Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/lcas_col_cell.sv
module lcas_col_cell (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           shift_i,
  input  logic           clear_i,
  input  lcas_pkg::col_t col_i,
  output lcas_pkg::col_t col_o
);
  import lcas_pkg::*;

  col_t col_q, col_d;

  always_comb begin
    col_d = col_q;
    if (clear_i) begin
      col_d = '0;
    end else if (shift_i) begin
      col_d = col_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
    end else begin
      col_q <= col_d;
    end
  end

  assign col_o = col_q;

endmodule

// File: rtl/life_cellular_automaton_step_top.sv
// One generation of the B3/S23 life rule over a raster stream of cell bits.
// The input channel carries one word per cell, row by row and left to right;
// a word with req_type set is a flush tick. Flush ticks before the last cell
// are dropped, and after the last cell W+1 words (flush or cell) drain the
// remaining results. The output channel carries the new state of each cell
// with its column, row and a flag on the final cell of the grid.
// A result belongs to the cell W+1 input words back and passes the window stage
// and output registers. One word is accepted every cycle unless the output
// stalls; the line store is a single 1024 x 2 RAM with one read and one write
// port, and two column cells hold the 3x3 window. The sizes are to be written
// through the configuration port while the block is idle, which the block does
// not enforce; each write clamps the value to 3..1024 and restarts the generation.
// Reset sets the grid to 640 x 480 and clears counters and window; the line
// store is not cleared, since no result depends on an unwritten entry. When the
// receiver stalls, the output register holds its word; a window-stage word that
// yields a result then holds too and input ready drops until the output is taken.
module life_cellular_automaton_step_top (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  lcas_in_if.sink                      in_i,
  lcas_out_if.source                   out_o,
  input  logic                         cfg_we_i,
  input  logic [lcas_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [lcas_pkg::SizeW-1:0]   cfg_data_i
);
  import lcas_pkg::*;

  logic [SizeW-1:0] width_q, width_d, height_q, height_d;
  logic [ColW-1:0]  in_col_q, in_col_d;
  logic [SizeW-1:0] in_row_q, in_row_d;
  logic [ColW-1:0]  out_col_q, out_col_d;
  logic [RowW-1:0]  out_row_q, out_row_d;

  logic             cfg_hit;
  logic             draining, take, accept;
  logic [ColW-1:0]  ix;
  logic             emit, last;
  logic [SizeW-1:0] col_inc, ocol_inc;
  logic             col_wrap, ocol_wrap;
  col_t             rowmask;

  logic             s1_valid_q, s1_valid_d, s1_go, out_free;
  stage_t           s1_q;
  logic [1:0]       rd;
  col_t             col, cell_a, cell_b, l_col, r_col;
  logic             win_clear;

  logic             out_valid_q, out_valid_d;
  res_t             out_q;

  // Configuration.
  always_comb begin
    width_d  = width_q;
    height_d = height_q;
    cfg_hit  = 1'b0;
    if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        IDX_GRID_WIDTH: begin
          width_d = clamp_size(cfg_data_i, MaxWidthV);
          cfg_hit = 1'b1;
        end
        IDX_GRID_HEIGHT: begin
          height_d = clamp_size(cfg_data_i, MaxHeightV);
          cfg_hit  = 1'b1;
        end
        default: begin
          cfg_hit = 1'b0;
        end
      endcase
    end
  end

  // Position tracking at the input and output.
  assign draining = in_row_q >= height_q;
  assign accept   = in_i.valid & in_i.ready;
  assign take     = accept & ~(in_i.req_type & ~draining);

  assign ix        = ({1'b0, in_col_q} >= width_q) ? '0 : in_col_q;
  assign emit      = (in_row_q >= SizeW'(2)) || ((in_row_q == SizeW'(1)) && (ix != '0));
  assign last      = ({1'b0, out_col_q} == width_q - SizeW'(1))
                  && ({1'b0, out_row_q} == height_q - SizeW'(1));
  assign col_inc   = {1'b0, ix} + SizeW'(1);
  assign col_wrap  = col_inc >= width_q;
  assign ocol_inc  = {1'b0, out_col_q} + SizeW'(1);
  assign ocol_wrap = ocol_inc >= width_q;
  assign rowmask   = {(({1'b0, out_row_q} + SizeW'(1)) < height_q), 1'b1, (out_row_q != '0)};

  always_comb begin
    in_col_d  = in_col_q;
    in_row_d  = in_row_q;
    out_col_d = out_col_q;
    out_row_d = out_row_q;
    if (cfg_hit || (take && emit && last)) begin
      in_col_d  = '0;
      in_row_d  = '0;
      out_col_d = '0;
      out_row_d = '0;
    end else if (take) begin
      if (emit) begin
        out_col_d = ocol_wrap ? '0 : ocol_inc[ColW-1:0];
        if (ocol_wrap) begin
          out_row_d = out_row_q + RowW'(1);
        end
      end
      in_col_d = col_wrap ? '0 : col_inc[ColW-1:0];
      if (col_wrap) begin
        in_row_d = in_row_q + SizeW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q   <= ResetWidth;
      height_q  <= ResetHeight;
      in_col_q  <= '0;
      in_row_q  <= '0;
      out_col_q <= '0;
      out_row_q <= '0;
    end else begin
      width_q   <= width_d;
      height_q  <= height_d;
      in_col_q  <= in_col_d;
      in_row_q  <= in_row_d;
      out_col_q <= out_col_d;
      out_row_q <= out_row_d;
    end
  end

  // Window stage.
  assign out_free   = ~out_valid_q | out_o.ready;
  assign s1_go      = s1_valid_q & (~s1_q.emit | out_free);
  assign in_i.ready = ~s1_valid_q | s1_go;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (take) begin
      s1_valid_d = 1'b1;
    end else if (s1_go) begin
      s1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      s1_q.v       <= draining ? 1'b0 : in_i.cell_alive;
      s1_q.ix      <= ix;
      s1_q.emit    <= emit;
      s1_q.ix0     <= (ix == '0);
      s1_q.lmask   <= (out_col_q != '0);
      s1_q.rowmask <= rowmask;
      s1_q.ox      <= out_col_q;
      s1_q.oy      <= out_row_q;
      s1_q.last    <= last;
    end
  end

  // Bit 0 holds the row above, bit 1 the current row.
  lcas_ram #(
    .Width (2),
    .Depth (MaxWidth)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (s1_go),
    .waddr_i (s1_q.ix),
    .wdata_i ({s1_q.v, rd[1]}),
    .re_i    (take),
    .raddr_i (ix),
    .rdata_o (rd)
  );

  assign col       = {s1_q.v, rd[1], rd[0]};
  assign win_clear = cfg_hit | (s1_go & s1_q.last);

  lcas_col_cell u_cell_a (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .shift_i (s1_go),
    .clear_i (win_clear),
    .col_i   (col),
    .col_o   (cell_a)
  );

  lcas_col_cell u_cell_b (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .shift_i (s1_go),
    .clear_i (win_clear),
    .col_i   (cell_a),
    .col_o   (cell_b)
  );

  assign l_col = s1_q.lmask ? cell_b : '0;
  assign r_col = s1_q.ix0 ? '0 : col;

  // Output register.
  always_comb begin
    out_valid_d = out_valid_q;
    if (s1_go && s1_q.emit) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_go && s1_q.emit) begin
      out_q.new_alive <= life_next(l_col, cell_a, r_col, s1_q.rowmask);
      out_q.cell_x    <= s1_q.ox;
      out_q.cell_y    <= s1_q.oy;
      out_q.last_cell <= s1_q.last;
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.new_alive = out_q.new_alive;
  assign out_o.cell_x    = out_q.cell_x;
  assign out_o.cell_y    = out_q.cell_y;
  assign out_o.last_cell = out_q.last_cell;

endmodule

// File: rtl/lcas_checker.sv
module lcas_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         cfg_we_i,
  input logic [lcas_pkg::CfgIdxW-1:0] cfg_idx_i,
  lcas_out_if.source                  out_o
);
  import lcas_pkg::*;

  logic            fire, cfg_hit;
  logic            origin_q, origin_d;
  logic [ColW-1:0] px_q;
  logic [RowW-1:0] py_q;

  assign fire    = out_o.valid & out_o.ready;
  assign cfg_hit = cfg_we_i && ((cfg_idx_i == IDX_GRID_WIDTH) ||
                                (cfg_idx_i == IDX_GRID_HEIGHT));

  always_comb begin
    origin_d = origin_q;
    if (cfg_hit) begin
      origin_d = 1'b1;
    end else if (fire) begin
      origin_d = out_o.last_cell;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      origin_q <= 1'b1;
    end else begin
      origin_q <= origin_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      px_q <= out_o.cell_x;
      py_q <= out_o.cell_y;
    end
  end

  a_reset_quiet: assert property (@(posedge clk_i) !rst_ni |-> !out_o.valid)
    else $error("result word valid during reset");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !out_o.ready |=> out_o.valid && $stable(out_o.cell_x)
      && $stable(out_o.cell_y) && $stable(out_o.new_alive) && $stable(out_o.last_cell))
    else $error("stalled result word changed");

  a_origin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && origin_q |-> out_o.cell_x == '0 && out_o.cell_y == '0)
    else $error("generation does not start at the origin");

  a_raster: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && !origin_q |->
      (out_o.cell_x == px_q + ColW'(1) && out_o.cell_y == py_q) ||
      (out_o.cell_x == '0 && out_o.cell_y == py_q + RowW'(1)))
    else $error("results out of raster order");

endmodule

bind life_cellular_automaton_step_top lcas_checker u_lcas_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .cfg_we_i  (cfg_we_i),
  .cfg_idx_i (cfg_idx_i),
  .out_o     (out_o)
);
